// File: rtl/stot_pkg.sv
// Shared types and constants for the sphere/triangle overlap pipeline.
`default_nettype none
package stot_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int REG_WIDTH       = 23;
	localparam int KIND_WIDTH      = 3;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int MUL_CHUNK       = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t centre_x;
		coord_t centre_y;
		coord_t centre_z;
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} in_item_t;

	typedef struct packed {
		logic                  hit;
		logic [KIND_WIDTH-1:0] contact_kind;
	} out_item_t;

	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_NONE   = 3'd0,
		KIND_PRUNED = 3'd1,
		KIND_VERTEX = 3'd2,
		KIND_EDGE   = 3'd3,
		KIND_FACE   = 3'd4
	} kind_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_RADIUS = 1'b0,
		REG_SIDE   = 1'b1
	} cfg_reg_t;

	// decisions available after the first sums
	typedef struct packed {
		logic       prune;
		logic       vert;
		logic [2:0] eez;
		logic [2:0] dok;
	} early_flags_t;

	// decisions available after the second sums
	typedef struct packed {
		logic [2:0] edge_hit;
		logic       face_side;
		logic       nn_zero;
	} late_flags_t;

endpackage
`default_nettype wire

// File: rtl/sphere_triangle_overlap_test.sv
// Throughput: one item per cycle; out_stall with a waiting result freezes every stage.
// Arithmetic is exact: three levels of products, the wide ones in 4-stage multipliers.
// Reset clears the stage valid bits and both registers (radius and side to 0).
// in_stall is high exactly while a result waits and out_stall is high.
`default_nettype none
module sphere_triangle_overlap_test (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  stot_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output stot_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [stot_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [stot_pkg::REG_WIDTH-1:0]       cfg_wdata
);
	import stot_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int D   = W + 1;           // coordinate difference
	localparam int P1  = 2 * D;           // product of two differences
	localparam int SW  = P1 + 2;          // sum of three such products
	localparam int CW  = P1 + 1;          // cross product component
	localparam int RW  = REG_WIDTH;
	localparam int RQ  = 2 * (RW + 1);    // r squared
	localparam int LQ  = 2 * (RW + 2);    // (m + r) squared
	localparam int Q2  = 2 * CW;
	localparam int Q2S = Q2 + 2;
	localparam int EEW = RQ + SW;
	localparam int PDW = D + CW;
	localparam int PDS = PDW + 2;
	localparam int NST = 13;

	localparam int NX [3] = '{1, 2, 0};
	localparam int PV [3] = '{2, 0, 1};

	logic [RW-1:0] radius_q, side_q;
	logic [NST:1]  valid_s;
	logic          adv;

	logic signed [W-1:0] vtx [3][3];
	logic signed [W-1:0] cen [3];

	// stage 1: differences, u = vertex - centre, e = edge vectors
	logic signed [D-1:0] u_s1 [3][3];
	logic signed [D-1:0] e_s1 [3][3];
	logic [RW-1:0]       r_s1;
	logic [RW:0]         lim_s1;

	// stage 2: first-level products
	logic signed [P1-1:0] uu_s2  [3][3];
	logic signed [P1-1:0] ee_s2  [3][3];
	logic signed [P1-1:0] crp_s2 [3][3];
	logic signed [P1-1:0] crn_s2 [3][3];
	logic signed [P1-1:0] dp_s2  [3][3];
	logic signed [P1-1:0] dq_s2  [3][3];
	logic signed [P1-1:0] nxp_s2 [3];
	logic signed [P1-1:0] nxn_s2 [3];
	logic signed [P1-1:0] bp_s2  [3][3];
	logic signed [P1-1:0] bn_s2  [3][3];
	logic signed [RQ-1:0] r2_s2;
	logic signed [LQ-1:0] lim2_s2;
	logic signed [D-1:0]  ua_s2 [3];

	// stage 3: first-level sums
	logic signed [SW-1:0] usq_s3 [3];
	logic signed [SW-1:0] esq_s3 [3];
	logic signed [CW-1:0] ecr_s3 [3][3];
	logic signed [SW-1:0] dp_s3  [3];
	logic signed [SW-1:0] dq_s3  [3];
	logic signed [CW-1:0] nv_s3  [3];
	logic signed [CW-1:0] bc_s3  [3][3];
	logic signed [RQ-1:0] r2_s3;
	logic signed [LQ-1:0] lim2_s3;
	logic signed [D-1:0]  ua_s3 [3];

	early_flags_t         efl_d;
	early_flags_t         efl_pipe_s [4:12];
	logic signed [RQ-1:0] r2_pipe_s  [4:8];

	// stage 7: second-level products out of the multipliers
	logic signed [Q2-1:0]  csq_s7  [3][3];
	logic signed [EEW-1:0] r2ee_s7 [3];
	logic signed [Q2-1:0]  nsq_s7  [3];
	logic signed [PDW-1:0] pdp_s7  [3];
	logic signed [Q2-1:0]  bd_s7   [3][3];

	// stage 8: second-level sums
	logic signed [Q2S-1:0] crsq_s8 [3];
	logic signed [EEW-1:0] r2ee_s8 [3];
	logic signed [Q2S-1:0] nn_s8;
	logic signed [PDS-1:0] pd_s8;
	logic signed [Q2S-1:0] bd_s8 [3];

	late_flags_t lfl_d;
	late_flags_t lfl_pipe_s [9:12];

	// stage 12: third-level products
	logic signed [2*PDS-1:0]  pdsq_s12;
	logic signed [RQ+Q2S-1:0] r2nn_s12;

	kind_t     kind_d;
	out_item_t out_s13;

	assign adv       = !(valid_s[NST] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = valid_s[NST];
	assign out_data  = out_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			side_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS: radius_q <= cfg_wdata;
				REG_SIDE:   side_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NST-1:1], in_valid};
		end
	end

	always_comb begin
		cen[0]    = in_data.centre_x;
		cen[1]    = in_data.centre_y;
		cen[2]    = in_data.centre_z;
		vtx[0][0] = in_data.a_x;
		vtx[0][1] = in_data.a_y;
		vtx[0][2] = in_data.a_z;
		vtx[1][0] = in_data.b_x;
		vtx[1][1] = in_data.b_y;
		vtx[1][2] = in_data.b_z;
		vtx[2][0] = in_data.c_x;
		vtx[2][1] = in_data.c_y;
		vtx[2][2] = in_data.c_z;
	end

	// stages 1 to 3
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 3; v++) begin
				for (int k = 0; k < 3; k++) begin
					u_s1[v][k] <= D'(vtx[v][k]) - D'(cen[k]);
					e_s1[v][k] <= D'(vtx[NX[v]][k]) - D'(vtx[v][k]);
				end
			end
			r_s1   <= radius_q;
			lim_s1 <= (RW+1)'(radius_q) + (RW+1)'(side_q);

			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					uu_s2[j][k]  <= u_s1[j][k] * u_s1[j][k];
					ee_s2[j][k]  <= e_s1[j][k] * e_s1[j][k];
					crp_s2[j][k] <= e_s1[j][NX[k]] * u_s1[j][PV[k]];
					crn_s2[j][k] <= e_s1[j][PV[k]] * u_s1[j][NX[k]];
					dp_s2[j][k]  <= e_s1[j][k] * u_s1[j][k];
					dq_s2[j][k]  <= e_s1[j][k] * u_s1[NX[j]][k];
					bp_s2[j][k]  <= u_s1[NX[j]][NX[k]] * u_s1[PV[j]][PV[k]];
					bn_s2[j][k]  <= u_s1[NX[j]][PV[k]] * u_s1[PV[j]][NX[k]];
				end
				// normal = (c - a) x (b - a) = e_ab x e_ca
				nxp_s2[j] <= e_s1[0][NX[j]] * e_s1[2][PV[j]];
				nxn_s2[j] <= e_s1[0][PV[j]] * e_s1[2][NX[j]];
				ua_s2[j]  <= u_s1[0][j];
			end
			r2_s2   <= RQ'(r_s1) * RQ'(r_s1);
			lim2_s2 <= LQ'(lim_s1) * LQ'(lim_s1);

			for (int j = 0; j < 3; j++) begin
				usq_s3[j] <= SW'(uu_s2[j][0]) + SW'(uu_s2[j][1]) + SW'(uu_s2[j][2]);
				esq_s3[j] <= SW'(ee_s2[j][0]) + SW'(ee_s2[j][1]) + SW'(ee_s2[j][2]);
				dp_s3[j]  <= SW'(dp_s2[j][0]) + SW'(dp_s2[j][1]) + SW'(dp_s2[j][2]);
				dq_s3[j]  <= SW'(dq_s2[j][0]) + SW'(dq_s2[j][1]) + SW'(dq_s2[j][2]);
				for (int k = 0; k < 3; k++) begin
					ecr_s3[j][k] <= CW'(crp_s2[j][k]) - CW'(crn_s2[j][k]);
					bc_s3[j][k]  <= CW'(bp_s2[j][k]) - CW'(bn_s2[j][k]);
				end
				nv_s3[j] <= CW'(nxp_s2[j]) - CW'(nxn_s2[j]);
				ua_s3[j] <= ua_s2[j];
			end
			r2_s3   <= r2_s2;
			lim2_s3 <= lim2_s2;
		end
	end

	always_comb begin
		efl_d.prune = (usq_s3[0] >= lim2_s3) || (usq_s3[1] >= lim2_s3);
		efl_d.vert  = (usq_s3[0] <= r2_s3) || (usq_s3[1] <= r2_s3) || (usq_s3[2] <= r2_s3);
		for (int j = 0; j < 3; j++) begin
			efl_d.eez[j] = (esq_s3[j] == '0);
			// centre projects between the edge's two ends
			efl_d.dok[j] = (dp_s3[j] <= 0) && (dq_s3[j] >= 0);
		end
	end

	// second-level products, stage 3 to stage 7
	for (genvar j = 0; j < 3; j++) begin : g_l2
		for (genvar k = 0; k < 3; k++) begin : g_comp
			sto_mul #(.AW(CW), .BW(CW)) u_csq (
				.clk(clk), .en(adv), .a(ecr_s3[j][k]), .b(ecr_s3[j][k]), .p(csq_s7[j][k])
			);
			sto_mul #(.AW(CW), .BW(CW)) u_bd (
				.clk(clk), .en(adv), .a(nv_s3[k]), .b(bc_s3[j][k]), .p(bd_s7[j][k])
			);
		end
		sto_mul #(.AW(RQ), .BW(SW)) u_r2ee (
			.clk(clk), .en(adv), .a(r2_s3), .b(esq_s3[j]), .p(r2ee_s7[j])
		);
		sto_mul #(.AW(CW), .BW(CW)) u_nsq (
			.clk(clk), .en(adv), .a(nv_s3[j]), .b(nv_s3[j]), .p(nsq_s7[j])
		);
		sto_mul #(.AW(D), .BW(CW)) u_pdp (
			.clk(clk), .en(adv), .a(ua_s3[j]), .b(nv_s3[j]), .p(pdp_s7[j])
		);
	end

	// stage 8 sums and the flag / radius delay lines
	always_ff @(posedge clk) begin
		if (adv) begin
			efl_pipe_s[4] <= efl_d;
			for (int i = 5; i <= 12; i++) begin
				efl_pipe_s[i] <= efl_pipe_s[i-1];
			end
			r2_pipe_s[4] <= r2_s3;
			for (int i = 5; i <= 8; i++) begin
				r2_pipe_s[i] <= r2_pipe_s[i-1];
			end
			for (int j = 0; j < 3; j++) begin
				crsq_s8[j] <= Q2S'(csq_s7[j][0]) + Q2S'(csq_s7[j][1]) + Q2S'(csq_s7[j][2]);
				bd_s8[j]   <= Q2S'(bd_s7[j][0]) + Q2S'(bd_s7[j][1]) + Q2S'(bd_s7[j][2]);
				r2ee_s8[j] <= r2ee_s7[j];
			end
			nn_s8 <= Q2S'(nsq_s7[0]) + Q2S'(nsq_s7[1]) + Q2S'(nsq_s7[2]);
			pd_s8 <= PDS'(pdp_s7[0]) + PDS'(pdp_s7[1]) + PDS'(pdp_s7[2]);
			lfl_pipe_s[9] <= lfl_d;
			for (int i = 10; i <= 12; i++) begin
				lfl_pipe_s[i] <= lfl_pipe_s[i-1];
			end
			out_s13.hit          <= (kind_d == KIND_VERTEX) || (kind_d == KIND_EDGE) ||
			                        (kind_d == KIND_FACE);
			out_s13.contact_kind <= kind_d;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lfl_d.edge_hit[j] = !efl_pipe_s[8].eez[j] && efl_pipe_s[8].dok[j] &&
			                    (crsq_s8[j] <= r2ee_s8[j]);
		end
		lfl_d.face_side = (bd_s8[0] <= 0) && (bd_s8[1] <= 0) && (bd_s8[2] <= 0);
		lfl_d.nn_zero   = (nn_s8 == '0);
	end

	// third-level products, stage 8 to stage 12
	sto_mul #(.AW(PDS), .BW(PDS)) u_pdsq (
		.clk(clk), .en(adv), .a(pd_s8), .b(pd_s8), .p(pdsq_s12)
	);
	sto_mul #(.AW(RQ), .BW(Q2S)) u_r2nn (
		.clk(clk), .en(adv), .a(r2_pipe_s[8]), .b(nn_s8), .p(r2nn_s12)
	);

	always_comb begin
		if (efl_pipe_s[12].prune) begin
			kind_d = KIND_PRUNED;
		end else if (efl_pipe_s[12].vert) begin
			kind_d = KIND_VERTEX;
		end else if (|lfl_pipe_s[12].edge_hit) begin
			kind_d = KIND_EDGE;
		end else if (!lfl_pipe_s[12].nn_zero && lfl_pipe_s[12].face_side &&
		             (pdsq_s12 <= r2nn_s12)) begin
			kind_d = KIND_FACE;
		end else begin
			kind_d = KIND_NONE;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sto_mul.sv
// Four-stage signed multiplier built from 16x16 partial products.
`default_nettype none
module sto_mul #(
	parameter int AW = 16,
	parameter int BW = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import stot_pkg::*;

	localparam int CH = MUL_CHUNK;
	localparam int NA = (AW + CH - 1) / CH;
	localparam int NB = (BW + CH - 1) / CH;
	localparam int AP = NA * CH;
	localparam int BP = NB * CH;
	localparam int PW = AP + BP;

	logic [AW-1:0]   abs_a;
	logic [BW-1:0]   abs_b;
	logic [AP-1:0]   mag_a_s1;
	logic [BP-1:0]   mag_b_s1;
	logic            neg_s1, neg_s2, neg_s3;
	logic [2*CH-1:0] pp_s2 [NA][NB];
	logic [PW-1:0]   row_d [NA];
	logic [PW-1:0]   row_s3 [NA];
	logic [PW-1:0]   tot_d;

	// most negative input maps to its magnitude as unsigned bits
	assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
	assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_d[i] = row_d[i] + (PW'(pp_s2[i][j]) << (CH * j));
			end
		end
	end

	always_comb begin
		tot_d = '0;
		for (int i = 0; i < NA; i++) begin
			tot_d = tot_d + (row_s3[i] << (CH * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1 <= AP'(abs_a);
			mag_b_s1 <= BP'(abs_b);
			neg_s1   <= a[AW-1] ^ b[BW-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= (2*CH)'(mag_a_s1[i*CH +: CH]) * (2*CH)'(mag_b_s1[j*CH +: CH]);
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_d;
			neg_s3 <= neg_s2;
			p      <= neg_s3 ? (AW+BW)'(-tot_d) : (AW+BW)'(tot_d);
		end
	end

endmodule
`default_nettype wire

// File: rtl/sto_chk.sv
// Port-level checks for the overlap pipeline, bound to the top level.
`default_nettype none
module sto_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input stot_pkg::out_item_t out_data
);
	import stot_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// the input side backs up only behind a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hit == ((out_data.contact_kind == KIND_VERTEX) ||
		                               (out_data.contact_kind == KIND_EDGE) ||
		                               (out_data.contact_kind == KIND_FACE)))
		else $error("hit disagrees with contact kind");

endmodule

bind sphere_triangle_overlap_test sto_chk u_sto_chk (.*);
`default_nettype wire
